// ----- rtl/smss_pkg.sv -----
// package: widths, formats, coefficient table and stage word type for the sine series unit
package smss_pkg;

    localparam int MAX_TERMS_DEF = 10;
    localparam int ANGLE_W = 32;
    localparam int SINE_W  = 32;
    localparam int XMAG_W  = 32;
    localparam int N_W     = 4;
    localparam int S_W     = 33;
    localparam int R_W     = 30;
    localparam int U_W     = 30;
    localparam int Q_W     = 33;
    localparam int V_W     = 35;
    localparam int MAG_W   = 39;

    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 3;

    localparam logic REG_TERM_COUNT = 1'b0;
    localparam logic [N_W-1:0] TERM_COUNT_RST = 4'd10;

    localparam logic signed [Q_W-1:0] Q_ONE = 33'sd268435456;
    localparam logic [V_W-1:0] Q_ONE_V = 35'd268435456;

    localparam logic [SINE_W-1:0] SINE_POS_MAX = 32'h7FFF_FFFF;
    localparam logic [MAG_W-1:0]  MAG_POS_MAX  = 39'h00_7FFF_FFFF;
    localparam logic [MAG_W-1:0]  MAG_NEG_MAX  = 39'h00_8000_0000;
    localparam logic [SINE_W-1:0] SINE_NEG_MAX = 32'h8000_0000;

    typedef struct packed {
        logic [XMAG_W-1:0]      xmag;
        logic                   xneg;
        logic [N_W-1:0]         n;
        logic [S_W-1:0]         s;
        logic signed [Q_W-1:0]  q;
    } smss_item_t;

    // ratio of consecutive reciprocal factorials, 1/((2k)(2k+1)), unsigned Q32
    function automatic logic [R_W-1:0] ratio_coef(input logic [3:0] k);
        logic [R_W-1:0] r;
        r = '0;
        unique case (k)
            4'd1:    r = 30'd715827883;
            4'd2:    r = 30'd214748365;
            4'd3:    r = 30'd102261126;
            4'd4:    r = 30'd59652324;
            4'd5:    r = 30'd39045157;
            4'd6:    r = 30'd27531842;
            4'd7:    r = 30'd20452225;
            4'd8:    r = 30'd15790321;
            4'd9:    r = 30'd12558384;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/smss_front.sv -----
// front end: angle magnitude, term count clamp and squaring, two stages
module smss_front
    import smss_pkg::*;
#(
    parameter int MAX_TERMS = MAX_TERMS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [ANGLE_W-1:0]  angle,
    input  logic [N_W-1:0]      term_count,
    output logic                out_valid,
    input  logic                out_ready,
    output smss_item_t          out_item
);

    logic                valid_a_reg;
    logic                valid_b_reg;
    logic                ready_a;
    logic                ready_b;
    logic [XMAG_W-1:0]   xmag_a_reg;
    logic [XMAG_W-1:0]   xmag_a_next;
    logic                xneg_a_reg;
    logic                xneg_a_next;
    logic [N_W-1:0]      n_a_reg;
    logic [N_W-1:0]      n_a_next;
    logic [2*XMAG_W-1:0] sq_prod;
    logic [2*XMAG_W-1:0] sq_sum;
    smss_item_t          item_b_reg;
    smss_item_t          item_b_next;

    assign ready_b  = !valid_b_reg || out_ready;
    assign ready_a  = !valid_a_reg || ready_b;
    assign in_ready = ready_a;

    always_comb
    begin
        xneg_a_next = angle[ANGLE_W-1];
        xmag_a_next = xneg_a_next ? (XMAG_W'(0) - angle) : angle;
        if (term_count == '0)
        begin
            n_a_next = N_W'(1);
        end
        else if (term_count > N_W'(MAX_TERMS))
        begin
            n_a_next = N_W'(MAX_TERMS);
        end
        else
        begin
            n_a_next = term_count;
        end
    end

    assign sq_prod = xmag_a_reg * xmag_a_reg;
    assign sq_sum  = sq_prod + (64'd1 << 29);

    always_comb
    begin
        item_b_next.xmag = xmag_a_reg;
        item_b_next.xneg = xneg_a_reg;
        item_b_next.n    = n_a_reg;
        item_b_next.s    = sq_sum[30 +: S_W];
        item_b_next.q    = Q_ONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end
        else
        begin
            if (ready_a)
            begin
                valid_a_reg <= in_valid;
            end
            if (ready_b)
            begin
                valid_b_reg <= valid_a_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_a && in_valid)
        begin
            xmag_a_reg <= xmag_a_next;
            xneg_a_reg <= xneg_a_next;
            n_a_reg    <= n_a_next;
        end
        if (ready_b && valid_a_reg)
        begin
            item_b_reg <= item_b_next;
        end
    end

    assign out_valid = valid_b_reg;
    assign out_item  = item_b_reg;

endmodule

// ----- rtl/smss_step.sv -----
// one horner step on x squared: coefficient product, then nested update of q
module smss_step
    import smss_pkg::*;
#(
    parameter int K = 1
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  smss_item_t  in_item,
    output logic        out_valid,
    input  logic        out_ready,
    output smss_item_t  out_item
);

    localparam logic [R_W-1:0] RK = ratio_coef(4'(K));

    logic                    valid_a_reg;
    logic                    valid_b_reg;
    logic                    ready_a;
    logic                    ready_b;
    logic [S_W+R_W-1:0]      su_prod;
    logic [63:0]             su_sum;
    logic [U_W-1:0]          u_a_reg;
    logic [U_W-1:0]          u_a_next;
    smss_item_t              item_a_reg;
    logic                    q_neg;
    logic [Q_W-1:0]          qm;
    logic [U_W+Q_W-1:0]      uq_prod;
    logic [63:0]             uq_sum;
    logic [V_W-1:0]          v;
    logic [V_W-1:0]          q_wide;
    logic                    active;
    smss_item_t              item_b_reg;
    smss_item_t              item_b_next;

    assign ready_b  = !valid_b_reg || out_ready;
    assign ready_a  = !valid_a_reg || ready_b;
    assign in_ready = ready_a;

    assign su_prod  = in_item.s * RK;
    assign su_sum   = {1'b0, su_prod} + (64'd1 << 31);
    assign u_a_next = su_sum[32 +: U_W];

    assign q_neg   = item_a_reg.q[Q_W-1];
    assign qm      = q_neg ? (Q_W'(0) - item_a_reg.q) : item_a_reg.q;
    assign uq_prod = u_a_reg * qm;
    assign uq_sum  = {1'b0, uq_prod} + (64'd1 << 27);
    assign v       = uq_sum[28 +: V_W];
    assign q_wide  = q_neg ? (Q_ONE_V + v) : (Q_ONE_V - v);
    assign active  = N_W'(K) < item_a_reg.n;

    always_comb
    begin
        item_b_next = item_a_reg;
        if (active)
        begin
            item_b_next.q = $signed(q_wide[Q_W-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end
        else
        begin
            if (ready_a)
            begin
                valid_a_reg <= in_valid;
            end
            if (ready_b)
            begin
                valid_b_reg <= valid_a_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_a && in_valid)
        begin
            item_a_reg <= in_item;
            u_a_reg    <= u_a_next;
        end
        if (ready_b && valid_a_reg)
        begin
            item_b_reg <= item_b_next;
        end
    end

    assign out_valid = valid_b_reg;
    assign out_item  = item_b_reg;

endmodule

// ----- rtl/smss_back.sv -----
// back end: final product x times q, rounding, saturation and output register
module smss_back
    import smss_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  smss_item_t         in_item,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [SINE_W-1:0]  sine
);

    logic                      valid_a_reg;
    logic                      valid_b_reg;
    logic                      ready_a;
    logic                      ready_b;
    logic                      q_neg;
    logic [Q_W-1:0]            qm;
    logic [XMAG_W+Q_W-1:0]     prod_a_reg;
    logic [XMAG_W+Q_W-1:0]     prod_a_next;
    logic                      neg_a_reg;
    logic                      neg_a_next;
    logic [XMAG_W+Q_W:0]       mag_sum;
    logic [MAG_W-1:0]          mag;
    logic [SINE_W-1:0]         sine_reg;
    logic [SINE_W-1:0]         sine_next;

    assign ready_b  = !valid_b_reg || !out_stall;
    assign ready_a  = !valid_a_reg || ready_b;
    assign in_ready = ready_a;

    assign q_neg       = in_item.q[Q_W-1];
    assign qm          = q_neg ? (Q_W'(0) - in_item.q) : in_item.q;
    assign prod_a_next = in_item.xmag * qm;
    assign neg_a_next  = in_item.xneg ^ q_neg;

    assign mag_sum = {1'b0, prod_a_reg} + ((XMAG_W+Q_W+1)'(1) << 26);
    assign mag     = mag_sum[27 +: MAG_W];

    always_comb
    begin
        if (!neg_a_reg)
        begin
            sine_next = (mag > MAG_POS_MAX) ? SINE_POS_MAX : mag[SINE_W-1:0];
        end
        else
        begin
            sine_next = (mag > MAG_NEG_MAX) ? SINE_NEG_MAX
                                            : (SINE_W'(0) - mag[SINE_W-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end
        else
        begin
            if (ready_a)
            begin
                valid_a_reg <= in_valid;
            end
            if (ready_b)
            begin
                valid_b_reg <= valid_a_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_a && in_valid)
        begin
            prod_a_reg <= prod_a_next;
            neg_a_reg  <= neg_a_next;
        end
        if (ready_b && valid_a_reg)
        begin
            sine_reg <= sine_next;
        end
    end

    assign out_valid = valid_b_reg;
    assign sine      = sine_reg;

endmodule

// ----- rtl/sine_maclaurin_series_unit.sv -----
// top level: sine by a pipelined maclaurin series with term count register
//
//  channel   handshake                    payload
//  input     in_valid / in_stall          angle  (signed Q3.29)
//  output    out_valid / out_stall        sine   (signed Q2.30, saturated)
//  config    psel penable pwrite pready   paddr pwdata prdata (term_count at 0x0)
//
//  one word enters per cycle while the output does not stall; the pipeline is
//  two front stages, two per horner step and two back stages
//  each stage holds its own valid bit and fills bubbles while the output stalls
//  reset clears all valid bits and sets term_count to ten
module sine_maclaurin_series_unit
    import smss_pkg::*;
#(
    parameter int MAX_TERMS = MAX_TERMS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic signed [ANGLE_W-1:0]  angle,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [SINE_W-1:0]   sine,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ADDR_W-1:0]          paddr,
    input  logic [DATA_W-1:0]          pwdata,
    output logic [DATA_W-1:0]          prdata,
    output logic                       pready
);

    logic [N_W-1:0]   term_count_reg;
    logic [N_W-1:0]   term_count_next;
    logic             cfg_write;
    logic             front_ready;

    logic             stg_valid [MAX_TERMS];
    logic             stg_ready [MAX_TERMS];
    smss_item_t       stg_item  [MAX_TERMS];

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_TERM_COUNT);

    always_comb
    begin
        term_count_next = term_count_reg;
        if (cfg_write)
        begin
            term_count_next = pwdata[N_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            term_count_reg <= TERM_COUNT_RST;
        end
        else
        begin
            term_count_reg <= term_count_next;
        end
    end

    assign prdata = (paddr[2] == REG_TERM_COUNT) ? DATA_W'(term_count_reg) : '0;

    smss_front #(
        .MAX_TERMS (MAX_TERMS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (front_ready),
        .angle      (angle),
        .term_count (term_count_reg),
        .out_valid  (stg_valid[0]),
        .out_ready  (stg_ready[0]),
        .out_item   (stg_item[0])
    );

    assign in_stall = !front_ready;

    // steps run from the highest series index down to one
    for (genvar j = 0; j < MAX_TERMS - 1; j++)
    begin : g_step
        smss_step #(
            .K (MAX_TERMS - 1 - j)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stg_valid[j]),
            .in_ready  (stg_ready[j]),
            .in_item   (stg_item[j]),
            .out_valid (stg_valid[j+1]),
            .out_ready (stg_ready[j+1]),
            .out_item  (stg_item[j+1])
        );
    end

    smss_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (stg_valid[MAX_TERMS-1]),
        .in_ready  (stg_ready[MAX_TERMS-1]),
        .in_item   (stg_item[MAX_TERMS-1]),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sine      (sine)
    );

endmodule

// ----- rtl/smss_checker.sv -----
// port checker for the sine series unit, bound to the top level
module smss_checker
    import smss_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_stall,
    input  logic                       out_valid,
    input  logic                       out_stall,
    input  logic signed [SINE_W-1:0]   sine,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ADDR_W-1:0]          paddr,
    input  logic [DATA_W-1:0]          pwdata,
    input  logic [DATA_W-1:0]          prdata
);

    // a stalled output word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(sine))
    else $error("stalled output word changed");

    // with the output free the whole pipeline can advance
    assert property (@(posedge clk) disable iff (!rst_n)
        !(out_valid && out_stall) |-> !in_stall)
    else $error("input stalled while output side is free");

    // term_count reads back what was written
    assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && paddr[2] == REG_TERM_COUNT)
        ##1 (paddr[2] == REG_TERM_COUNT)
        |-> prdata == DATA_W'($past(pwdata[N_W-1:0])))
    else $error("term_count readback mismatch");

    // no word leaves right out of reset
    assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

bind sine_maclaurin_series_unit smss_checker u_smss_checker (.*);
